// ===== hw/rtl/char_lcd_4bit_write_sequencer_unit_macros.svh =====
// Assertion macros for the character LCD write sequencer.
// Clock clk and active-low reset rst_n are taken from the including module.
`ifndef CHAR_LCD_4BIT_WRITE_SEQUENCER_UNIT_MACROS_SVH
`define CHAR_LCD_4BIT_WRITE_SEQUENCER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Condition must hold on every clock edge out of reset
`define CLCD_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Antecedent on one edge implies consequent on the next
`define CLCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CLCD_ASSERT(lbl, cond, msg)
`define CLCD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/clcd_pkg.sv =====
// Shared types, codes and the microcode ROM of the character LCD sequencer.
// No dependencies.
`default_nettype none
package clcd_pkg;

  // Request codes
  localparam logic [2:0] FUNC_INIT   = 3'd0;
  localparam logic [2:0] FUNC_CMD    = 3'd1;
  localparam logic [2:0] FUNC_CHAR   = 3'd2;
  localparam logic [2:0] FUNC_MOVE   = 3'd3;
  localparam logic [2:0] FUNC_NIBBLE = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_STROBE = 2'd0;
  localparam logic [1:0] REG_POWER  = 2'd1;
  localparam logic [1:0] REG_SECOND = 2'd2;
  localparam logic [1:0] REG_THIRD  = 2'd3;

  // Register reset values
  localparam logic [19:0] StrobeReset = 20'h01500;
  localparam logic [23:0] PowerReset  = 24'h07FFFF;
  localparam logic [23:0] SecondReset = 24'h00FFFF;
  localparam logic [23:0] ThirdReset  = 24'h0005DC;

  // Cursor address bases
  localparam logic [7:0] Line1Base = 8'h80;
  localparam logic [7:0] Line2Base = 8'hC0;

  // Program layout
  localparam int PcW = 6;
  localparam logic [PcW-1:0] PcInit     = 6'd0;
  localparam logic [PcW-1:0] PcInitByte = 6'd11;
  localparam logic [PcW-1:0] PcInitEnd  = 6'd31;
  localparam logic [PcW-1:0] PcByte     = 6'd32;
  localparam logic [PcW-1:0] PcNibble   = 6'd37;
  localparam logic [PcW-1:0] ProgLen    = 6'd40;

  typedef enum logic [1:0] {
    NIB_CONST = 2'd0,
    NIB_HI    = 2'd1,
    NIB_LO    = 2'd2
  } nib_sel_t;

  typedef enum logic [2:0] {
    HOLD_STROBE = 3'd0,
    HOLD_POWER  = 3'd1,
    HOLD_SECOND = 3'd2,
    HOLD_THIRD  = 3'd3,
    HOLD_ZERO   = 3'd4
  } hold_sel_t;

  // One control word per step
  typedef struct packed {
    logic      rs_req;    // rs follows the request, else low
    logic      en;
    nib_sel_t  nib_sel;
    logic [3:0] nib_const;
    hold_sel_t hold_sel;
    logic      last;      // final state, returns to idle
  } ucode_t;

  localparam logic [7:0] InitBytes [5] = '{8'h28, 8'h08, 8'h01, 8'h06, 8'h0F};

  function automatic ucode_t mk(logic rs_req, logic en, nib_sel_t sel, logic [3:0] k,
                                hold_sel_t hs, logic lst);
    ucode_t w;
    w.rs_req    = rs_req;
    w.en        = en;
    w.nib_sel   = sel;
    w.nib_const = k;
    w.hold_sel  = hs;
    w.last      = lst;
    return w;
  endfunction

  // Microcode ROM
  function automatic ucode_t rom_word(logic [PcW-1:0] pc);
    ucode_t     w;
    logic [4:0] idx;
    logic [7:0] b;
    idx = 5'(pc - PcInitByte);
    b   = InitBytes[3'(idx[4:2])];
    case (pc)
      6'd0:  w = mk(1'b0, 1'b0, NIB_CONST, 4'h0, HOLD_POWER,  1'b0);
      6'd1:  w = mk(1'b0, 1'b0, NIB_CONST, 4'h3, HOLD_STROBE, 1'b0);
      6'd2:  w = mk(1'b0, 1'b1, NIB_CONST, 4'h3, HOLD_STROBE, 1'b0);
      6'd3:  w = mk(1'b0, 1'b0, NIB_CONST, 4'h3, HOLD_SECOND, 1'b0);
      6'd4:  w = mk(1'b0, 1'b0, NIB_CONST, 4'h3, HOLD_STROBE, 1'b0);
      6'd5:  w = mk(1'b0, 1'b1, NIB_CONST, 4'h3, HOLD_STROBE, 1'b0);
      6'd6:  w = mk(1'b0, 1'b0, NIB_CONST, 4'h3, HOLD_THIRD,  1'b0);
      6'd7:  w = mk(1'b0, 1'b0, NIB_CONST, 4'h3, HOLD_STROBE, 1'b0);
      6'd8:  w = mk(1'b0, 1'b1, NIB_CONST, 4'h3, HOLD_STROBE, 1'b0);
      6'd9:  w = mk(1'b0, 1'b0, NIB_CONST, 4'h2, HOLD_STROBE, 1'b0);
      6'd10: w = mk(1'b0, 1'b1, NIB_CONST, 4'h2, HOLD_STROBE, 1'b0);
      6'd31: w = mk(1'b0, 1'b0, NIB_CONST, 4'hF, HOLD_ZERO,   1'b1);
      // generic byte: setup/pulse high nibble, setup/pulse low nibble, final
      6'd32: w = mk(1'b1, 1'b0, NIB_HI, 4'h0, HOLD_STROBE, 1'b0);
      6'd33: w = mk(1'b1, 1'b1, NIB_HI, 4'h0, HOLD_STROBE, 1'b0);
      6'd34: w = mk(1'b1, 1'b0, NIB_LO, 4'h0, HOLD_STROBE, 1'b0);
      6'd35: w = mk(1'b1, 1'b1, NIB_LO, 4'h0, HOLD_STROBE, 1'b0);
      6'd36: w = mk(1'b0, 1'b0, NIB_LO, 4'h0, HOLD_ZERO,   1'b1);
      // single nibble
      6'd37: w = mk(1'b0, 1'b0, NIB_HI, 4'h0, HOLD_STROBE, 1'b0);
      6'd38: w = mk(1'b0, 1'b1, NIB_HI, 4'h0, HOLD_STROBE, 1'b0);
      6'd39: w = mk(1'b0, 1'b0, NIB_HI, 4'h0, HOLD_ZERO,   1'b1);
      default: begin
        if (pc >= PcInitByte && pc < PcInitEnd) begin
          // init bytes, four steps each
          w = mk(1'b0, idx[0], NIB_CONST, idx[1] ? b[3:0] : b[7:4], HOLD_STROBE, 1'b0);
        end else begin
          w = mk(1'b0, 1'b0, NIB_CONST, 4'h0, HOLD_ZERO, 1'b1);
        end
      end
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/char_lcd_4bit_write_sequencer_unit.sv =====
// Character LCD 4-bit write sequencer: top level, microcoded step engine.
// Depends on clcd_pkg and char_lcd_4bit_write_sequencer_unit_macros.svh.
//
// Usage:
//   in_*  : one request item per handshake. Requests are init, command byte,
//           character, move cursor and single nibble. Unused codes and
//           non-printable characters are taken and produce no items.
//   out_* : timed pin states (rs, en, nibble, hold ticks); out_tlast marks the
//           final state of a request.
//   cfg_* : APB-style write/read of the four timing registers, pready tied high.
// Timing: a request is taken when the sequencer is free; busy and the step counter
//   are registered on accept, then the output register loads the first pin state,
//   and one state follows per cycle while out_tready is high. An init request gives
//   32 states, a byte request 5 states, a nibble request 3 states; a dropped
//   request gives none. The step counter walking the microcode ROM sets these
//   figures: one ROM word per result.
//   The next request is taken as soon as the final state of the current one
//   sits in the output register.
// Reset: timing registers return to their defaults, sequencer idle, no output.
// Stall: a low out_tready with a valid output state freezes the output register and the step counter.
`default_nettype none
`include "char_lcd_4bit_write_sequencer_unit_macros.svh"
module char_lcd_4bit_write_sequencer_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // func[2:0], code_byte[10:3], row[18:11], column[26:19]
  // pin-state stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // reg_select[0], enable_pin[1], data_nibble[5:2],
                                       // hold_ticks[29:6]
  output logic             out_tlast,  // last
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int PcW = clcd_pkg::PcW;

  // Timing registers
  logic [19:0] strobe_r;
  logic [23:0] power_r;
  logic [23:0] second_r;
  logic [23:0] third_r;
  logic [1:0]  reg_idx;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= clcd_pkg::StrobeReset;
      power_r  <= clcd_pkg::PowerReset;
      second_r <= clcd_pkg::SecondReset;
      third_r  <= clcd_pkg::ThirdReset;
    end else if (cfg_wr) begin
      case (reg_idx)
        clcd_pkg::REG_STROBE: strobe_r <= cfg_pwdata[19:0];
        clcd_pkg::REG_POWER:  power_r  <= cfg_pwdata[23:0];
        clcd_pkg::REG_SECOND: second_r <= cfg_pwdata[23:0];
        clcd_pkg::REG_THIRD:  third_r  <= cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (reg_idx)
      clcd_pkg::REG_STROBE: cfg_prdata = {12'd0, strobe_r};
      clcd_pkg::REG_POWER:  cfg_prdata = {8'd0, power_r};
      clcd_pkg::REG_SECOND: cfg_prdata = {8'd0, second_r};
      clcd_pkg::REG_THIRD:  cfg_prdata = {8'd0, third_r};
      default:              cfg_prdata = 32'd0;
    endcase
  end

  // Request fields
  logic [2:0] in_func;
  logic [7:0] in_code;
  logic [7:0] in_row;
  logic [7:0] in_col;
  assign in_func = in_tdata[2:0];
  assign in_code = in_tdata[10:3];
  assign in_row  = in_tdata[18:11];
  assign in_col  = in_tdata[26:19];

  // Sequencer control
  logic           busy_r, busy_nxt;
  logic [PcW-1:0] pc_r, pc_nxt;
  logic [7:0]     byte_r, byte_nxt;
  logic           rs_r, rs_nxt;
  logic           in_acc;
  logic           out_load;
  logic           printable;
  clcd_pkg::ucode_t uc;

  assign in_tready = !busy_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = busy_r && (!out_tvalid || out_tready);
  assign uc        = clcd_pkg::rom_word(pc_r);
  assign printable = (in_code inside {[8'h20:8'h7F]}) || (in_code >= 8'hA0);

  // Entry decode on accept, step advance on output load
  always_comb begin
    busy_nxt = busy_r;
    pc_nxt   = pc_r;
    byte_nxt = byte_r;
    rs_nxt   = rs_r;
    if (in_acc) begin
      byte_nxt = in_code;
      rs_nxt   = 1'b0;
      case (in_func)
        clcd_pkg::FUNC_INIT: begin
          busy_nxt = 1'b1;
          pc_nxt   = clcd_pkg::PcInit;
        end
        clcd_pkg::FUNC_CMD: begin
          busy_nxt = 1'b1;
          pc_nxt   = clcd_pkg::PcByte;
        end
        clcd_pkg::FUNC_CHAR: begin
          busy_nxt = printable;
          rs_nxt   = 1'b1;
          pc_nxt   = clcd_pkg::PcByte;
        end
        clcd_pkg::FUNC_MOVE: begin
          busy_nxt = 1'b1;
          pc_nxt   = clcd_pkg::PcByte;
          byte_nxt = ((in_row != 8'd0) ? clcd_pkg::Line2Base : clcd_pkg::Line1Base) + in_col;
        end
        clcd_pkg::FUNC_NIBBLE: begin
          busy_nxt = 1'b1;
          pc_nxt   = clcd_pkg::PcNibble;
        end
        default: busy_nxt = 1'b0;
      endcase
    end else if (out_load) begin
      pc_nxt = pc_r + 1'b1;
      if (uc.last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r   <= clcd_pkg::PcInit;
    end else begin
      busy_r <= busy_nxt;
      pc_r   <= pc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    rs_r   <= rs_nxt;
  end

  // Datapath: pin levels selected by the control word
  logic [3:0]  nib_val;
  logic [23:0] hold_val;

  always_comb begin
    case (uc.nib_sel)
      clcd_pkg::NIB_HI: nib_val = byte_r[7:4];
      clcd_pkg::NIB_LO: nib_val = byte_r[3:0];
      default:          nib_val = uc.nib_const;
    endcase
    case (uc.hold_sel)
      clcd_pkg::HOLD_STROBE: hold_val = {4'd0, strobe_r};
      clcd_pkg::HOLD_POWER:  hold_val = power_r;
      clcd_pkg::HOLD_SECOND: hold_val = second_r;
      clcd_pkg::HOLD_THIRD:  hold_val = third_r;
      default:               hold_val = 24'd0;
    endcase
  end

  // Output register
  logic        out_valid_r;
  logic [29:0] out_data_r;
  logic        out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {hold_val, nib_val, uc.en, uc.rs_req & rs_r};
      out_last_r <= uc.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_data_r};
  assign out_tlast  = out_last_r;

  // Checks
  `CLCD_ASSERT(a_pc_range, !busy_r || (pc_r < clcd_pkg::ProgLen), "step counter out of program")
  `CLCD_ASSERT_NEXT(a_last_frees, out_load && uc.last, !busy_r, "sequencer busy after final step")
  `CLCD_ASSERT_NEXT(a_no_accept_busy, busy_r && !(out_load && uc.last), !in_tready,
                    "request ready while a program runs")
  `CLCD_ASSERT(a_final_state, !(out_tvalid && out_tlast) ||
               (!out_tdata[1] && !out_tdata[0] && (out_tdata[29:6] == 24'd0)),
               "final state not idle pins with zero hold")

endmodule
`default_nettype wire
